// File: hw/rtl/spi_nor_command_sequencer_defines.svh
// Assertion macros for the SPI NOR command sequencer checkers.
`ifndef SPI_NOR_COMMAND_SEQUENCER_DEFINES_SVH
`define SPI_NOR_COMMAND_SEQUENCER_DEFINES_SVH

// Same-cycle implication, clocked on aclk, quiet during reset.
`define SNC_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, quiet during reset.
`define SNC_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hw/rtl/snc_pkg.sv
`timescale 1ns / 1ps

package snc_pkg;

    // input function codes
    localparam logic [2:0] FN_READ  = 3'd0;
    localparam logic [2:0] FN_WRITE = 3'd1;
    localparam logic [2:0] FN_ERASE = 3'd2;
    localparam logic [2:0] FN_DONE  = 3'd3;
    localparam logic [2:0] FN_TICK  = 3'd4;

    // operation in progress
    localparam logic [1:0] OPN_READ  = 2'd0;
    localparam logic [1:0] OPN_WRITE = 2'd1;
    localparam logic [1:0] OPN_ERASE = 2'd2;

    // SPI NOR command bytes
    localparam logic [7:0] OP_WREN = 8'h06;
    localparam logic [7:0] OP_PP   = 8'h02;
    localparam logic [7:0] OP_SE   = 8'h20;
    localparam logic [7:0] OP_READ = 8'h03;
    localparam logic [7:0] OP_RDSR = 8'h05;
    localparam logic [7:0] OP_NONE = 8'h00;

    localparam int unsigned SR_WIP_BIT = 0;

    // result kinds and finish outcomes
    localparam logic       KIND_ISSUE  = 1'b0;
    localparam logic       KIND_FINISH = 1'b1;
    localparam logic [1:0] OUT_OK      = 2'd0;
    localparam logic [1:0] OUT_REFUSED = 2'd1;
    localparam logic [1:0] OUT_FAILED  = 2'd2;

    localparam logic [8:0] PAGE_BYTES = 9'd256;
    localparam logic [5:0] WRITE_MAX  = 6'd60;
    localparam logic [6:0] READ_MAX   = 7'd64;

    localparam logic [23:0] BASE_RESET    = 24'd0;
    localparam logic [31:0] TIMEOUT_RESET = 32'd80000000;

    // configuration register byte addresses
    localparam logic [2:0] ADDR_PROT_BASE = 3'd0;
    localparam logic [2:0] ADDR_TIMEOUT   = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_READ = 5'b00010,
        PH_WREN = 5'b00100,
        PH_PROG = 5'b01000,
        PH_POLL = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  operation;
        logic [23:0] cur_address;
        logic [23:0] remaining;
        logic [23:0] done_bytes;
        logic [6:0]  chunk_bytes;
        logic [31:0] wait_ticks;
    } state_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [23:0] address;
        logic [23:0] length;
        logic [7:0]  status_byte;
        logic        xfer_failed;
    } item_t;

    typedef struct packed {
        logic [23:0] protected_base;
        logic [31:0] busy_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  opcode;
        logic        has_address;
        logic [23:0] spi_address;
        logic [5:0]  tx_count;
        logic [6:0]  rx_count;
        logic [23:0] buffer_offset;
        logic [1:0]  outcome;
    } result_t;

endpackage

// File: hw/rtl/spi_nor_command_sequencer.sv
`timescale 1ns / 1ps

// SPI NOR command sequencer. Takes read, write and sector-erase requests plus
// transaction-done and tick events on the s_ channel, and hands out a
// transaction descriptor (or an operation-finished record) on the m_ channel
// per request or done event it acts on; ticks give none. One transaction per
// cycle while m_ready is high; result in the cycle after acceptance, held in
// the output register. s_ready drops only while a result sits in that register
// and m_ready is low. Reads go out in chunks of up to 64 bytes; writes are cut
// at 256-byte pages and 60 bytes, each chunk as WREN, PP, then RDSR polls;
// erases run WREN, SE on the sector base, then the poll. Writes and erases
// below protected_base are refused. Configuration (APB, byte address 0
// protected_base, 4 busy_timeout_ticks) must only be written while idle.
module spi_nor_command_sequencer #(
    parameter int unsigned SECTOR_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,

    // request / event channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [23:0] s_address,
    input  logic [23:0] s_length,
    input  logic [7:0]  s_status_byte,
    input  logic        s_xfer_failed,

    // descriptor / completion channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_opcode,
    output logic        m_has_address,
    output logic [23:0] m_spi_address,
    output logic [5:0]  m_tx_count,
    output logic [6:0]  m_rx_count,
    output logic [23:0] m_buffer_offset,
    output logic [1:0]  m_outcome,

    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Sector base by reciprocal multiply: q = (addr * RECIP) >> SHIFT is
    // exact for any 24-bit address, so the divisor need not be a power of two.
    localparam int unsigned SECT_LOG   = $clog2(SECTOR_BYTES);
    localparam int unsigned SECT_SHIFT = 24 + SECT_LOG;
    localparam int unsigned RECIP_W    = 26;
    localparam int unsigned PROD_W     = 24 + RECIP_W;
    localparam int unsigned Q_W        = 24 - SECT_LOG + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SECT_SHIFT) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES);
    localparam logic [RECIP_W-1:0] SECT_RECIP = RECIP_W'(RECIP_FULL);
    localparam logic [23:0]        SECT_SIZE  = 24'(SECTOR_BYTES);

    snc_pkg::state_t  state_reg;
    snc_pkg::state_t  state_next;
    snc_pkg::cfg_t    cfg_reg;
    snc_pkg::result_t out_reg;
    snc_pkg::result_t res;
    snc_pkg::item_t   item;
    logic             res_valid;
    logic             out_valid_reg;
    logic [Q_W-1:0]   sect_q_reg;
    logic [PROD_W-1:0] sect_prod;
    logic [23:0]      sector_base;
    logic             s_accept;
    logic             cfg_write;

    assign item = '{func:        s_func,
                    address:     s_address,
                    length:      s_length,
                    status_byte: s_status_byte,
                    xfer_failed: s_xfer_failed};

    // output register frees up in the same cycle it is drained
    assign s_ready  = !out_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign sect_prod   = PROD_W'(s_address) * PROD_W'(SECT_RECIP);
    assign sector_base = 24'(sect_q_reg) * SECT_SIZE;

    snc_step u_step (
        .st          (state_reg),
        .item        (item),
        .cfg         (cfg_reg),
        .sector_base (sector_base),
        .st_next     (state_next),
        .res         (res),
        .res_valid   (res_valid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase       <= snc_pkg::PH_IDLE;
            state_reg.operation   <= snc_pkg::OPN_READ;
            state_reg.cur_address <= '0;
            state_reg.remaining   <= '0;
            state_reg.done_bytes  <= '0;
            state_reg.chunk_bytes <= '0;
            state_reg.wait_ticks  <= '0;
            out_valid_reg         <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (s_accept && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            out_reg <= res;
        end
        // latch the sector quotient whenever an erase request is accepted while idle
        if (s_accept && s_func == snc_pkg::FN_ERASE
                && state_reg.phase == snc_pkg::PH_IDLE) begin
            sect_q_reg <= Q_W'(sect_prod >> SECT_SHIFT);
        end
    end

    // configuration registers
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.protected_base     <= snc_pkg::BASE_RESET;
            cfg_reg.busy_timeout_ticks <= snc_pkg::TIMEOUT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == snc_pkg::ADDR_TIMEOUT[2]) begin
                cfg_reg.busy_timeout_ticks <= pwdata;
            end else begin
                cfg_reg.protected_base <= pwdata[23:0];
            end
        end
    end

    assign prdata = (paddr[2] == snc_pkg::ADDR_PROT_BASE[2])
                  ? {8'd0, cfg_reg.protected_base}
                  : cfg_reg.busy_timeout_ticks;

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_opcode        = out_reg.opcode;
    assign m_has_address   = out_reg.has_address;
    assign m_spi_address   = out_reg.spi_address;
    assign m_tx_count      = out_reg.tx_count;
    assign m_rx_count      = out_reg.rx_count;
    assign m_buffer_offset = out_reg.buffer_offset;
    assign m_outcome       = out_reg.outcome;

endmodule

// File: hw/rtl/snc_step.sv
`timescale 1ns / 1ps

// Next-state and result logic for one transaction on the input channel.
module snc_step (
    input  snc_pkg::state_t  st,
    input  snc_pkg::item_t   item,
    input  snc_pkg::cfg_t    cfg,
    input  logic [23:0]      sector_base,
    output snc_pkg::state_t  st_next,
    output snc_pkg::result_t res,
    output logic             res_valid
);

    function automatic logic [6:0] read_chunk(input logic [23:0] rem);
        read_chunk = (rem > 24'(snc_pkg::READ_MAX)) ? snc_pkg::READ_MAX : rem[6:0];
    endfunction

    // smallest of remaining, room left in the page, and the write limit
    function automatic logic [6:0] write_chunk(input logic [23:0] addr,
                                               input logic [23:0] rem);
        logic [8:0] page_room;
        logic [8:0] c;
        page_room = snc_pkg::PAGE_BYTES - {1'b0, addr[7:0]};
        c = (rem > 24'(page_room)) ? page_room : rem[8:0];
        if (c > 9'(snc_pkg::WRITE_MAX)) begin
            c = 9'(snc_pkg::WRITE_MAX);
        end
        write_chunk = c[6:0];
    endfunction

    logic [23:0] adv_address;
    logic [23:0] adv_done;
    logic [23:0] adv_remaining;

    assign adv_address   = st.cur_address + 24'(st.chunk_bytes);
    assign adv_done      = st.done_bytes + 24'(st.chunk_bytes);
    assign adv_remaining = st.remaining - 24'(st.chunk_bytes);

    always_comb begin
        st_next   = st;
        res       = '0;
        res_valid = 1'b0;

        case (item.func) inside
            snc_pkg::FN_READ, snc_pkg::FN_WRITE, snc_pkg::FN_ERASE: begin
                if (st.phase == snc_pkg::PH_IDLE) begin
                    st_next.done_bytes  = '0;
                    st_next.chunk_bytes = '0;
                    st_next.wait_ticks  = '0;
                    st_next.operation   = item.func[1:0];
                    res_valid           = 1'b1;
                    if (item.func == snc_pkg::FN_READ) begin
                        st_next.cur_address = item.address;
                        st_next.remaining   = item.length;
                        if (item.length == '0) begin
                            res.kind = snc_pkg::KIND_FINISH;
                            res.outcome = snc_pkg::OUT_OK;
                        end else begin
                            st_next.chunk_bytes = read_chunk(item.length);
                            st_next.phase       = snc_pkg::PH_READ;
                            res.opcode          = snc_pkg::OP_READ;
                            res.has_address     = 1'b1;
                            res.spi_address     = item.address;
                            res.rx_count        = read_chunk(item.length);
                        end
                    end else if (item.address < cfg.protected_base) begin
                        res.kind    = snc_pkg::KIND_FINISH;
                        res.outcome = snc_pkg::OUT_REFUSED;
                    end else if (item.func == snc_pkg::FN_WRITE) begin
                        st_next.cur_address = item.address;
                        st_next.remaining   = item.length;
                        if (item.length == '0) begin
                            res.kind    = snc_pkg::KIND_FINISH;
                            res.outcome = snc_pkg::OUT_OK;
                        end else begin
                            st_next.chunk_bytes = write_chunk(item.address, item.length);
                            st_next.phase       = snc_pkg::PH_WREN;
                            res.opcode          = snc_pkg::OP_WREN;
                        end
                    end else begin
                        // erase: sector base is held aside by the top level
                        st_next.cur_address = item.address;
                        st_next.remaining   = '0;
                        st_next.phase       = snc_pkg::PH_WREN;
                        res.opcode          = snc_pkg::OP_WREN;
                    end
                end
            end

            snc_pkg::FN_TICK: begin
                if (st.phase == snc_pkg::PH_POLL && st.wait_ticks != '1) begin
                    st_next.wait_ticks = st.wait_ticks + 32'd1;
                end
            end

            snc_pkg::FN_DONE: begin
                if (st.phase != snc_pkg::PH_IDLE) begin
                    res_valid = 1'b1;
                    if (item.xfer_failed) begin
                        st_next.phase = snc_pkg::PH_IDLE;
                        res.kind      = snc_pkg::KIND_FINISH;
                        res.outcome   = snc_pkg::OUT_FAILED;
                    end else begin
                        case (st.phase)
                            snc_pkg::PH_READ: begin
                                st_next.cur_address = adv_address;
                                st_next.done_bytes  = adv_done;
                                st_next.remaining   = adv_remaining;
                                if (adv_remaining == '0) begin
                                    st_next.phase = snc_pkg::PH_IDLE;
                                    res.kind      = snc_pkg::KIND_FINISH;
                                    res.outcome   = snc_pkg::OUT_OK;
                                end else begin
                                    st_next.chunk_bytes = read_chunk(adv_remaining);
                                    res.opcode          = snc_pkg::OP_READ;
                                    res.has_address     = 1'b1;
                                    res.spi_address     = adv_address;
                                    res.rx_count        = read_chunk(adv_remaining);
                                    res.buffer_offset   = adv_done;
                                end
                            end
                            snc_pkg::PH_WREN: begin
                                st_next.phase   = snc_pkg::PH_PROG;
                                res.has_address = 1'b1;
                                if (st.operation == snc_pkg::OPN_WRITE) begin
                                    res.opcode        = snc_pkg::OP_PP;
                                    res.spi_address   = st.cur_address;
                                    res.tx_count      = st.chunk_bytes[5:0];
                                    res.buffer_offset = st.done_bytes;
                                end else begin
                                    res.opcode      = snc_pkg::OP_SE;
                                    res.spi_address = sector_base;
                                end
                            end
                            snc_pkg::PH_PROG: begin
                                st_next.wait_ticks = '0;
                                st_next.phase      = snc_pkg::PH_POLL;
                                res.opcode         = snc_pkg::OP_RDSR;
                                res.rx_count       = 7'd1;
                            end
                            snc_pkg::PH_POLL: begin
                                if (!item.status_byte[snc_pkg::SR_WIP_BIT]) begin
                                    if (st.operation != snc_pkg::OPN_WRITE) begin
                                        st_next.phase = snc_pkg::PH_IDLE;
                                        res.kind      = snc_pkg::KIND_FINISH;
                                        res.outcome   = snc_pkg::OUT_OK;
                                    end else begin
                                        st_next.cur_address = adv_address;
                                        st_next.done_bytes  = adv_done;
                                        st_next.remaining   = adv_remaining;
                                        if (adv_remaining == '0) begin
                                            st_next.phase = snc_pkg::PH_IDLE;
                                            res.kind      = snc_pkg::KIND_FINISH;
                                            res.outcome   = snc_pkg::OUT_OK;
                                        end else begin
                                            st_next.chunk_bytes =
                                                write_chunk(adv_address, adv_remaining);
                                            st_next.phase = snc_pkg::PH_WREN;
                                            res.opcode    = snc_pkg::OP_WREN;
                                        end
                                    end
                                end else if (st.wait_ticks > cfg.busy_timeout_ticks) begin
                                    st_next.phase = snc_pkg::PH_IDLE;
                                    res.kind      = snc_pkg::KIND_FINISH;
                                    res.outcome   = snc_pkg::OUT_FAILED;
                                end else begin
                                    res.opcode   = snc_pkg::OP_RDSR;
                                    res.rx_count = 7'd1;
                                end
                            end
                            default: begin
                                st_next.phase = snc_pkg::PH_IDLE;
                                res_valid     = 1'b0;
                            end
                        endcase
                    end
                end
            end

            default: begin
                // unused function codes are dropped
            end
        endcase
    end

endmodule

// File: hw/rtl/snc_checker.sv
`timescale 1ns / 1ps
`include "spi_nor_command_sequencer_defines.svh"

module snc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [7:0]  m_opcode,
    input logic        m_has_address,
    input logic [23:0] m_spi_address,
    input logic [5:0]  m_tx_count,
    input logic [6:0]  m_rx_count,
    input logic [23:0] m_buffer_offset,
    input logic [1:0]  m_outcome
);

    // nothing waiting on the output means no stall on the input
    `SNC_ASSERT_IMP(a_ready_when_empty, !m_valid, s_ready, "s_ready low with empty output")

    `SNC_ASSERT_IMP(a_finish_clean, m_valid && m_kind == snc_pkg::KIND_FINISH, m_opcode == snc_pkg::OP_NONE && !m_has_address && m_spi_address == 24'd0 && m_tx_count == 6'd0 && m_rx_count == 7'd0 && m_buffer_offset == 24'd0 && m_outcome != 2'd3, "finish record carries a header")

    `SNC_ASSERT_IMP(a_issue_sane, m_valid && m_kind == snc_pkg::KIND_ISSUE, m_outcome == snc_pkg::OUT_OK && m_tx_count <= snc_pkg::WRITE_MAX && m_rx_count <= snc_pkg::READ_MAX && m_opcode != snc_pkg::OP_NONE, "bad descriptor")

    `SNC_ASSERT_NXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_opcode) && $stable(m_spi_address), "result changed while stalled")

endmodule

bind spi_nor_command_sequencer snc_checker u_snc_checker (.*);
